// File: rtl/lkr_pkg.sv
// Shared types, constants and handshake structs for the LRU-K frame replacer.
package lkr_pkg;

  localparam int unsigned FRAME_CNT      = 64;
  localparam int unsigned MAX_K_DEF      = 8;
  localparam int unsigned STAMP_BITS_DEF = 32;

  localparam int unsigned FRAME_W  = $clog2(FRAME_CNT);
  localparam int unsigned EVC_W    = $clog2(FRAME_CNT + 1);
  localparam int unsigned HDEPTH_W = 4;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [HDEPTH_W-1:0] HDEPTH_RST = 4'd2;

  typedef enum logic [1:0] {
    MODE_RECORD = 2'd0,
    MODE_SET_EV = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_EVICT  = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [FRAME_W-1:0] frame;
    logic               evictable_flag;
  } in_t;

  typedef struct packed {
    logic               victim_found;
    logic [FRAME_W-1:0] victim_frame;
    logic [EVC_W-1:0]   evictable_count;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_APPLY,
    ST_SCAN,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic load;
    logic apply;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/lkr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lkr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lkr_ctrl.sv
// Command sequencer: accept, metadata read, apply, victim scan and result.
module lkr_ctrl import lkr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  mode_e in_mode_i,
  output logic  in_ready_o,
  input  sts_t  sts_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_mode_i == MODE_EVICT) ? ST_SCAN : ST_READ;
        end
      end
      ST_READ:  state_d = ST_APPLY;
      ST_APPLY: state_d = ST_RESULT;
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_APPLY:  cmd_o.apply  = 1'b1;
      ST_SCAN:   cmd_o.scan   = 1'b1;
      ST_RESULT: cmd_o.finish = sts_i.out_free;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// File: rtl/lkr_dp.sv
// Datapath: frame metadata, stamp history memory, victim scan and result register.
module lkr_dp import lkr_pkg::*; #(
  parameter int unsigned MAX_K      = MAX_K_DEF,
  parameter int unsigned STAMP_BITS = STAMP_BITS_DEF,
  localparam int unsigned KW        = $clog2(MAX_K + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cmd_t          cmd_i,
  output sts_t          sts_o,
  input  in_t           in_data_i,
  input  logic [KW-1:0] k_i,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output out_t          out_data_o
);

  localparam int unsigned FW  = $clog2(FRAME_CNT);
  localparam int unsigned HW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int unsigned SW  = KW + 1;
  localparam int unsigned MW  = 1 + KW + HW;
  localparam int unsigned SAW = (FRAME_CNT * MAX_K > 1) ? $clog2(FRAME_CNT * MAX_K) : 1;
  localparam int unsigned SCW = $clog2(FRAME_CNT + 1);
  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

  function automatic logic [HW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= SW'(MAX_K)) ? s - SW'(MAX_K) : s;
    return r[HW-1:0];
  endfunction

  function automatic logic [SAW-1:0] base(input logic [FW-1:0] f);
    return SAW'(f) * SAW'(MAX_K);
  endfunction

  in_t                   item_q;
  logic [FRAME_CNT-1:0]  tracked_q, tracked_d;
  logic [SCW-1:0]        total_q, total_d;
  logic [STAMP_BITS-1:0] now_q, now_d;

  logic [SCW-1:0]        scan_cnt_q, scan_cnt_d;
  logic                  v1_q, v1_d, v2_q, v2_d;
  logic [FW-1:0]         f1_q, f2_q;
  logic                  inf2_q;
  logic                  found_q, found_d, have_inf_q, have_inf_d;
  logic [FW-1:0]         best_q, best_d;
  logic [STAMP_BITS-1:0] best_st_q, best_st_d;

  logic                  out_valid_q;
  out_t                  out_q;

  logic [FW-1:0]         item_idx;
  logic                  in_range;
  logic                  meta_we;
  logic [MW-1:0]         meta_wdata, meta_rdata;
  logic [FW-1:0]         meta_raddr;
  logic                  m_ev;
  logic [KW-1:0]         m_cnt;
  logic [HW-1:0]         m_head;
  logic                  stamp_we;
  logic [SAW-1:0]        stamp_waddr, stamp_raddr;
  logic [STAMP_BITS-1:0] stamp_rdata;

  logic                  trk, ev_e;
  logic [KW-1:0]         cnt_e, cnt_n;
  logic [HW-1:0]         head_e, head_n;
  logic [SW-1:0]         cnt1, drop;
  logic                  cand1, inf1;
  logic [KW-1:0]         pos1;
  logic                  evict_hit;

  assign item_idx   = FW'(item_q.frame);
  assign in_range   = 32'(item_q.frame) < FRAME_CNT;
  assign meta_raddr = cmd_i.scan ? FW'(scan_cnt_q) : item_idx;
  assign m_ev       = meta_rdata[MW-1];
  assign m_cnt      = meta_rdata[KW+HW-1:HW];
  assign m_head     = meta_rdata[HW-1:0];

  lkr_ram #(.WIDTH(MW), .DEPTH(FRAME_CNT)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (item_idx),
    .wdata_i (meta_wdata),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rdata)
  );

  lkr_ram #(.WIDTH(STAMP_BITS), .DEPTH(FRAME_CNT * MAX_K)) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (stamp_we),
    .waddr_i (stamp_waddr),
    .wdata_i (now_q),
    .raddr_i (stamp_raddr),
    .rdata_o (stamp_rdata)
  );

  // apply record, set evictable and remove, and retire the evict victim on finish
  always_comb begin
    trk         = tracked_q[item_idx];
    ev_e        = trk & m_ev;
    cnt_e       = trk ? m_cnt : '0;
    head_e      = trk ? m_head : '0;
    cnt1        = SW'(cnt_e) + SW'(1);
    drop        = cnt1 - SW'(k_i);
    if (cnt1 > SW'(k_i)) begin
      head_n = wrap(SW'(head_e) + drop);
      cnt_n  = k_i;
    end else begin
      head_n = head_e;
      cnt_n  = cnt1[KW-1:0];
    end
    stamp_waddr = base(item_idx) + SAW'(wrap(SW'(head_e) + SW'(cnt_e)));
    meta_we     = 1'b0;
    meta_wdata  = {ev_e, cnt_n, head_n};
    stamp_we    = 1'b0;
    tracked_d   = tracked_q;
    total_d     = total_q;
    now_d       = now_q;
    evict_hit   = (item_q.mode == MODE_EVICT) && found_q;
    if (cmd_i.apply && in_range) begin
      case (item_q.mode)
        MODE_RECORD: begin
          stamp_we            = 1'b1;
          meta_we             = 1'b1;
          tracked_d[item_idx] = 1'b1;
          if (now_q != STAMP_MAX) begin
            now_d = now_q + STAMP_BITS'(1);
          end
        end
        MODE_SET_EV: begin
          if (trk && (ev_e != item_q.evictable_flag)) begin
            meta_we    = 1'b1;
            meta_wdata = {item_q.evictable_flag, m_cnt, m_head};
            if (item_q.evictable_flag) begin
              total_d = total_q + SCW'(1);
            end else if (total_q != '0) begin
              total_d = total_q - SCW'(1);
            end
          end
        end
        MODE_REMOVE: begin
          if (trk) begin
            tracked_d[item_idx] = 1'b0;
            if (ev_e && (total_q != '0)) begin
              total_d = total_q - SCW'(1);
            end
          end
        end
        default: begin
          meta_we = 1'b0;
        end
      endcase
    end
    if (cmd_i.finish && evict_hit) begin
      tracked_d[best_q] = 1'b0;
      if (total_q != '0) begin
        total_d = total_q - SCW'(1);
      end
    end
  end

  // scan: metadata stage, then stamp stage
  always_comb begin
    cand1       = tracked_q[f1_q] & m_ev;
    inf1        = m_cnt < k_i;
    pos1        = inf1 ? '0 : m_cnt - k_i;
    stamp_raddr = base(f1_q) + SAW'(wrap(SW'(m_head) + SW'(pos1)));
    scan_cnt_d  = scan_cnt_q;
    v1_d        = 1'b0;
    v2_d        = v1_q & cand1;
    found_d     = found_q;
    have_inf_d  = have_inf_q;
    best_d      = best_q;
    best_st_d   = best_st_q;
    if (cmd_i.scan && (32'(scan_cnt_q) < FRAME_CNT)) begin
      v1_d       = 1'b1;
      scan_cnt_d = scan_cnt_q + SCW'(1);
    end
    if (v2_q) begin
      if (inf2_q) begin
        if (!have_inf_q || (stamp_rdata < best_st_q)) begin
          have_inf_d = 1'b1;
          found_d    = 1'b1;
          best_d     = f2_q;
          best_st_d  = stamp_rdata;
        end
      end else if (!have_inf_q) begin
        if (!found_q || (stamp_rdata < best_st_q)) begin
          found_d   = 1'b1;
          best_d    = f2_q;
          best_st_d = stamp_rdata;
        end
      end
    end
    if (cmd_i.load) begin
      scan_cnt_d = '0;
      v1_d       = 1'b0;
      v2_d       = 1'b0;
      found_d    = 1'b0;
      have_inf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracked_q   <= '0;
      total_q     <= '0;
      now_q       <= '0;
      scan_cnt_q  <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      found_q     <= 1'b0;
      have_inf_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tracked_q   <= tracked_d;
      total_q     <= total_d;
      now_q       <= now_d;
      scan_cnt_q  <= scan_cnt_d;
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      found_q     <= found_d;
      have_inf_q  <= have_inf_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    f1_q      <= FW'(scan_cnt_q);
    f2_q      <= f1_q;
    inf2_q    <= inf1;
    best_q    <= best_d;
    best_st_q <= best_st_d;
    if (cmd_i.finish) begin
      out_q.victim_found    <= evict_hit;
      out_q.victim_frame    <= evict_hit ? FRAME_W'(best_q) : '0;
      out_q.evictable_count <= EVC_W'(total_d);
    end
  end

  assign sts_o.scan_done = (32'(scan_cnt_q) >= FRAME_CNT) && !v1_q && !v2_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

endmodule

// File: rtl/lru_k_frame_replacer.sv
// LRU-K frame replacer top level: configuration port, sequencer and datapath.
// Record, set evictable and remove pass through the read, apply and result states before out_valid;
// evict scans instead, one frame per cycle through the metadata RAM, then enters the result state.
// One command in flight; the next beat is accepted only once the last result is registered,
// later while a finished result waits in the output register.
// Reset: all frames untracked, evictable count and timestamp zero, K = 2; no clearing pass.
module lru_k_frame_replacer import lkr_pkg::*; #(
  parameter int unsigned MAX_K      = MAX_K_DEF,
  parameter int unsigned STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned KW = $clog2(MAX_K + 1);

  logic [HDEPTH_W-1:0] hdepth_q;
  logic [KW-1:0]       k_eff;
  cmd_t                cmd;
  sts_t                sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdepth_q <= HDEPTH_RST;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      hdepth_q <= pwdata[HDEPTH_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : PDATA_W'(hdepth_q);

  always_comb begin
    if (hdepth_q == '0) begin
      k_eff = KW'(1);
    end else if (32'(hdepth_q) > MAX_K) begin
      k_eff = KW'(MAX_K);
    end else begin
      k_eff = KW'(hdepth_q);
    end
  end

  lkr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_data_i.mode),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lkr_dp #(
    .MAX_K      (MAX_K),
    .STAMP_BITS (STAMP_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .k_i         (k_eff),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// File: tb/tb.sv
// Self-checking testbench for the LRU-K frame replacer: scoreboarded commands and K settings.
`timescale 1ns / 100ps
module tb;
  import lkr_pkg::*;

  localparam int NF = 64;
  localparam int MK = 8;
  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  always #5 clk = ~clk;

  lru_k_frame_replacer dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [3:0] k_reg;
  bit is_tracked [NF];
  bit is_evict [NF];
  logic [31:0] stamps [NF][MK];
  int hcnt [NF];
  int hhead [NF];
  logic [31:0] now_ts;
  int ev_total;

  in_t cmd_q[$];
  out_t expected_q[$];
  int send_idle = 24, recv_idle = 54;
  bit hold_send = 1'b0;
  bit in_ready_seen = 1'b0;
  int errors = 0;
  int cycles = 0;

  function automatic int eff_k();
    if (k_reg < 1) return 1;
    if (k_reg > MK) return MK;
    return k_reg;
  endfunction

  function automatic void wipe(int f);
    is_tracked[f] = 0; is_evict[f] = 0; hcnt[f] = 0; hhead[f] = 0;
  endfunction

  function automatic out_t predict_replacer(in_t c);
    out_t r;
    int k, f, slot, best, cnt;
    bit found, have_inf;
    logic [31:0] best_old, best_gap, old, gap;
    r = '0; k = eff_k(); f = c.frame;
    found = 0; have_inf = 0; best = 0; best_old = '0; best_gap = '0;
    case (c.mode)
      MODE_RECORD: begin
        if (!is_tracked[f]) begin
          wipe(f);
          is_tracked[f] = 1;
        end
        slot = (hhead[f] + hcnt[f]) % MK;
        stamps[f][slot] = now_ts;
        hcnt[f]++;
        if (hcnt[f] > k) begin
          hhead[f] = (hhead[f] + hcnt[f] - k) % MK;
          hcnt[f] = k;
        end
        if (now_ts != 32'hFFFF_FFFF) now_ts++;
      end
      MODE_SET_EV: begin
        if (is_tracked[f] && is_evict[f] != c.evictable_flag) begin
          if (c.evictable_flag) ev_total++;
          else if (ev_total > 0) ev_total--;
          is_evict[f] = c.evictable_flag;
        end
      end
      MODE_REMOVE: begin
        if (is_tracked[f]) begin
          if (is_evict[f] && ev_total > 0) ev_total--;
          wipe(f);
        end
      end
      default: begin
        for (int i = 0; i < NF; i++) begin
          if (!is_tracked[i] || !is_evict[i]) continue;
          cnt = hcnt[i];
          if (cnt < k) begin
            old = stamps[i][hhead[i] % MK];
            if (!have_inf || old < best_old) begin
              have_inf = 1; best_old = old; best = i; found = 1;
            end
          end else if (!have_inf) begin
            gap = now_ts - stamps[i][(hhead[i] + cnt - k) % MK];
            if (!found || gap > best_gap) begin
              best_gap = gap; best = i; found = 1;
            end
          end
        end
        if (found) begin
          wipe(best);
          if (ev_total > 0) ev_total--;
          r.victim_found = 1'b1;
          r.victim_frame = best[FRAME_W-1:0];
        end
      end
    endcase
    r.evictable_count = ev_total[EVC_W-1:0];
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready_seen) begin
        if (cmd_q.size() > 0 && !hold_send && $urandom_range(99) >= send_idle) begin
          in_data <= cmd_q[0];
          cmd_q.delete(0);
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    out_t exp_r;
    cycles <= cycles + 1;
    in_ready_seen <= in_valid && in_ready;
    if (in_valid && in_ready) expected_q = {expected_q, predict_replacer(in_data)};
    if (out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", out_data);
      end else begin
        exp_r = expected_q[0];
        expected_q.delete(0);
        if (exp_r !== out_data) begin
          errors++;
          if (errors <= 10) $display("mismatch exp %p got %p", exp_r, out_data);
        end
      end
    end
    if (cycles >= LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic write_depth(input logic [3:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {28'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    k_reg = v;
  endtask

  task automatic drain();
    while (cmd_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic push(mode_e m, int f, bit fl);
    in_t c;
    c.mode = m; c.frame = f[FRAME_W-1:0]; c.evictable_flag = fl;
    cmd_q = {cmd_q, c};
  endtask

  // mostly well-formed traffic over a small working set, plus full-range noise
  task automatic random_batch(int n);
    int f;
    for (int i = 0; i < n; i++) begin
      f = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(11);
      case ($urandom_range(9))
        0, 1, 2, 3: push(MODE_RECORD, f, $urandom_range(1));
        4, 5: push(MODE_SET_EV, f, ($urandom_range(3) != 0));
        6: push(MODE_REMOVE, f, $urandom_range(1));
        default: push(MODE_EVICT, $urandom_range(63), $urandom_range(1));
      endcase
    end
  endtask

  initial begin
    k_reg = HDEPTH_RST;
    now_ts = '0; ev_total = 0;
    for (int i = 0; i < NF; i++) wipe(i);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // directed: empty evict, ignored ops, full-K distance, extremes
    push(MODE_EVICT, 0, 0);
    push(MODE_SET_EV, 5, 1);
    push(MODE_REMOVE, 5, 0);
    push(MODE_RECORD, 0, 0);
    push(MODE_RECORD, 63, 1);
    push(MODE_RECORD, 0, 0);
    push(MODE_RECORD, 63, 0);
    push(MODE_SET_EV, 0, 1);
    push(MODE_SET_EV, 63, 1);
    push(MODE_SET_EV, 63, 1);
    push(MODE_EVICT, 0, 0);
    push(MODE_EVICT, 0, 0);
    push(MODE_RECORD, 7, 0);
    push(MODE_REMOVE, 7, 0);
    push(MODE_RECORD, 9, 0);
    push(MODE_SET_EV, 9, 1);
    push(MODE_SET_EV, 9, 0);
    push(MODE_SET_EV, 9, 1);
    push(MODE_REMOVE, 9, 1);
    push(MODE_RECORD, 42, 1);
    push(MODE_SET_EV, 42, 1);
    push(MODE_EVICT, 63, 1);
    drain();
    write_depth(4'd0);
    random_batch(100);
    repeat (150) @(posedge clk);
    hold_send = 1'b1;
    while (in_valid || expected_q.size() > 0) @(posedge clk);
    hold_send = 1'b0;
    drain();
    write_depth(4'd1);
    random_batch(120);
    drain();
    write_depth(4'd15);
    random_batch(140);
    send_idle = 54; recv_idle = 24;
    drain();
    write_depth(4'd8);
    random_batch(140);
    drain();
    write_depth(4'd3);
    random_batch(140);
    send_idle = 0; recv_idle = 0;
    drain();
    write_depth(4'd2);
    random_batch(160);
    drain();
    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule
